// File: hw/rtl/wmp_pkg.sv
// Shared types and constants for the Weyl-mix PRNG with SplitMix64 seeding.
// No dependencies.
package wmp_pkg;

  typedef logic [63:0] word_t;
  typedef logic [3:0]  op_t;
  typedef logic [1:0]  dest_t;

  localparam word_t GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam word_t SM_MUL_A     = 64'hbf58_476d_1ce4_e5b9;
  localparam word_t SM_MUL_B     = 64'h94d0_49bb_1331_11eb;
  localparam word_t WEYL_STEP    = 64'h9999_9999_9999_9999;

  // datapath operations
  localparam op_t OP_IDLE    = 4'd0;
  localparam op_t OP_LOAD    = 4'd1;
  localparam op_t OP_ADD     = 4'd2;
  localparam op_t OP_MUL0    = 4'd3;
  localparam op_t OP_MUL1    = 4'd4;
  localparam op_t OP_MUL2    = 4'd5;
  localparam op_t OP_XS27    = 4'd6;
  localparam op_t OP_STORE   = 4'd7;
  localparam op_t OP_ADVANCE = 4'd8;
  localparam op_t OP_NEXT    = 4'd9;

  // state word written by a SplitMix draw
  localparam dest_t DST_MIX  = 2'd0;
  localparam dest_t DST_LOOP = 2'd1;
  localparam dest_t DST_WEYL = 2'd2;

  typedef struct packed {
    op_t   op;
    logic  const_sel;  // 0: SM_MUL_A, 1: SM_MUL_B
    dest_t dest;
  } dp_cmd_t;

endpackage

// File: hw/rtl/wmp_datapath.sv
// Datapath: generator state, SplitMix64 scratch registers, one shared 32x32 multiplier.
// Depends on wmp_pkg.
module wmp_datapath (
  input  logic           clk,
  input  logic           rst,
  input  wmp_pkg::dp_cmd_t cmd,
  input  wmp_pkg::word_t seed_value,
  output wmp_pkg::word_t random_value
);
  import wmp_pkg::*;

  word_t mix;
  word_t loop_mix;
  word_t weyl;
  word_t seq;
  word_t z;
  word_t acc;
  word_t result;

  word_t       seq_sum;
  word_t       mul_k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  word_t       prod;
  word_t       draw_out;
  word_t       mix_step;

  assign seq_sum  = seq + GOLDEN_GAMMA;
  assign mul_k    = cmd.const_sel ? SM_MUL_B : SM_MUL_A;
  assign mul_a    = (cmd.op == OP_MUL1) ? z[63:32] : z[31:0];
  assign mul_b    = (cmd.op == OP_MUL2) ? mul_k[63:32] : mul_k[31:0];
  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign draw_out = acc ^ (acc >> 31);
  // rotl(mix,16) + rotl(loop_mix,40)
  assign mix_step = {mix[47:0], mix[63:48]} + {loop_mix[23:0], loop_mix[63:24]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mix      <= '0;
      loop_mix <= '0;
      weyl     <= '0;
    end else begin
      unique case (cmd.op)
        OP_STORE: begin
          unique case (cmd.dest)
            DST_MIX:  mix      <= draw_out;
            DST_LOOP: loop_mix <= draw_out;
            default:  weyl     <= draw_out;
          endcase
        end
        OP_ADVANCE, OP_NEXT: begin
          loop_mix <= weyl ^ mix;
          mix      <= mix_step;
          weyl     <= weyl + WEYL_STEP;
        end
        default: ;
      endcase
    end
  end

  // scratch and output registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: seq <= seed_value;
      OP_ADD: begin
        seq <= seq_sum;
        z   <= seq_sum ^ (seq_sum >> 30);
      end
      OP_MUL0: acc <= prod;
      // cross terms only reach the upper half
      OP_MUL1, OP_MUL2: acc <= acc + {prod[31:0], 32'd0};
      OP_XS27: z <= acc ^ (acc >> 27);
      OP_NEXT: result <= mix + loop_mix;
      default: ;
    endcase
  end

  assign random_value = result;

endmodule

// File: hw/rtl/wmp_ctrl.sv
// Controller: handshakes, result valid flag and the reseed sequencer.
// Depends on wmp_pkg.
module wmp_ctrl #(
  parameter int WARMUP_ROUNDS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             action,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  output wmp_pkg::dp_cmd_t cmd
);
  import wmp_pkg::*;

  localparam int WCW = (WARMUP_ROUNDS > 1) ? $clog2(WARMUP_ROUNDS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_MUL0  = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_XS27  = 3'd5;
  localparam logic [2:0] S_STORE = 3'd6;
  localparam logic [2:0] S_WARM  = 3'd7;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic           pass;       // 0: first multiply of a draw, 1: second
  logic           pass_next;
  dest_t          draw;
  dest_t          draw_next;
  logic [WCW-1:0] warm_cnt;
  logic [WCW-1:0] warm_cnt_next;
  logic           result_valid_next;
  logic           accept;

  assign item_stall = (state != S_IDLE) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next    = state;
    pass_next     = pass;
    draw_next     = draw;
    warm_cnt_next = warm_cnt;
    cmd           = '{op: OP_IDLE, const_sel: pass, dest: draw};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action) begin
            cmd.op = OP_NEXT;
          end else begin
            cmd.op     = OP_LOAD;
            pass_next  = 1'b0;
            draw_next  = DST_MIX;
            state_next = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.op     = OP_MUL0;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op     = OP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = OP_MUL2;
        state_next = pass ? S_STORE : S_XS27;
      end
      S_XS27: begin
        cmd.op     = OP_XS27;
        pass_next  = 1'b1;
        state_next = S_MUL0;
      end
      S_STORE: begin
        cmd.op    = OP_STORE;
        pass_next = 1'b0;
        if (draw == DST_WEYL) begin
          warm_cnt_next = '0;
          state_next    = (WARMUP_ROUNDS > 0) ? S_WARM : S_IDLE;
        end else begin
          draw_next  = draw + dest_t'(1);
          state_next = S_ADD;
        end
      end
      default: begin
        cmd.op        = OP_ADVANCE;
        warm_cnt_next = warm_cnt + WCW'(1);
        if (warm_cnt == WCW'(WARMUP_ROUNDS - 1)) state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (accept && action) result_valid_next = 1'b1;
    else if (!result_stall) result_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pass         <= 1'b0;
      draw         <= DST_MIX;
      warm_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pass         <= pass_next;
      draw         <= draw_next;
      warm_cnt     <= warm_cnt_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

// File: hw/rtl/weyl_mix_prng_with_splitmix_seed.sv
// A next word gives its result in the cycle after acceptance; one next word per cycle while
// the output is not stalled. A reseed word runs three SplitMix64 draws in turn on the one
// shared 32x32 multiplier, then WARMUP_ROUNDS warm-up rounds, and gives no result.
// Synchronous active-high reset clears all generator state to zero and empties the output.
// Top level; depends on wmp_pkg, wmp_ctrl and wmp_datapath.
module weyl_mix_prng_with_splitmix_seed #(
  parameter int WARMUP_ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic [63:0] seed_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] random_value
);
  import wmp_pkg::*;

  dp_cmd_t cmd;

  wmp_ctrl #(
    .WARMUP_ROUNDS(WARMUP_ROUNDS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .action       (action),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  wmp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .seed_value   (seed_value),
    .random_value (random_value)
  );

endmodule

// File: hw/rtl/wmp_checker.sv
// Port-level checks for the Weyl-mix PRNG top level, bound to it below.
// Depends on the top level's ports only.
module wmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        action,
  input logic        result_valid,
  input logic        result_stall,
  input logic [63:0] random_value
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  a_value_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(random_value))
    else $error("stalled result word changed");

  a_next_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && action |=> result_valid)
    else $error("next word gave no result");

  a_reseed_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !action |=> item_stall)
    else $error("input taken during reseed");

endmodule

bind weyl_mix_prng_with_splitmix_seed wmp_checker u_wmp_checker (.*);

// File: tb/weyl_mix_prng_with_splitmix_seed_tb.sv
// Self-checking testbench for weyl_mix_prng_with_splitmix_seed: a directed table, then random
// next/reseed words, checked against an in-bench model of the generator state.
// Depends on wmp_pkg and the RTL of the block.
module weyl_mix_prng_with_splitmix_seed_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmp_pkg::*;

  localparam int WARMUP      = 16;
  localparam int RANDOM_WORDS = 1030;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 300;   // words sent before the long output hold
  localparam int QUIET_START = 3000;
  localparam int QUIET_END   = 4500;
  localparam int DRAIN_CYCLES = 80;   // covers a trailing reseed and its warm-up

  localparam logic ACT_RESEED = 1'b0;
  localparam logic ACT_NEXT   = 1'b1;

  typedef struct packed {
    logic  act;
    word_t seed;
    logic  known;
    word_t want;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  item_valid;
  logic  item_stall;
  logic  action;
  logic  [63:0] seed_value;
  logic  result_valid;
  logic  result_stall;
  logic  [63:0] random_value;

  word_t gen_mix, gen_loop, gen_weyl;
  word_t expected_randoms [$];
  int    mismatches = 0;
  int    words_sent = 0;
  int    cycle_count = 0;

  // From reset: the first two words are zero, the third is one Weyl step.
  stim_row_t directed_rows [0:20] = '{
    '{ACT_NEXT,   64'h0,                   1'b1, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b1, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b1, 64'h9999_9999_9999_9999},
    '{ACT_RESEED, 64'h0,                   1'b0, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b0, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b0, 64'h0},
    '{ACT_RESEED, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b0, 64'h0},
    '{ACT_RESEED, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b0, 64'h0},
    '{ACT_RESEED, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
    '{ACT_NEXT,   64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b0, 64'h0},
    '{ACT_RESEED, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{ACT_RESEED, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
    '{ACT_NEXT,   64'h5555_5555_5555_5555, 1'b0, 64'h0},
    '{ACT_RESEED, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b0, 64'h0},
    '{ACT_NEXT,   64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
    '{ACT_RESEED, 64'hfedc_ba98_7654_3210, 1'b0, 64'h0},
    '{ACT_NEXT,   64'h0,                   1'b0, 64'h0}
  };

  weyl_mix_prng_with_splitmix_seed #(.WARMUP_ROUNDS(WARMUP)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .seed_value   (seed_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .random_value (random_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit quiet_stretch();
    return cycle_count >= QUIET_START && cycle_count < QUIET_END;
  endfunction

  function automatic word_t splitmix_finish(word_t z);
    z = (z ^ (z >> 30)) * SM_MUL_A;
    z = (z ^ (z >> 27)) * SM_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // One generator step; returns the word and moves the state on.
  function automatic word_t gen_advance();
    word_t sum, prior_loop;
    sum        = gen_mix + gen_loop;
    prior_loop = gen_loop;
    gen_loop   = gen_weyl ^ gen_mix;
    gen_mix    = {gen_mix[47:0], gen_mix[63:48]} + {prior_loop[23:0], prior_loop[63:24]};
    gen_weyl   = gen_weyl + WEYL_STEP;
    return sum;
  endfunction

  function automatic void gen_reseed(word_t seed);
    word_t seq;
    word_t discard;
    seq      = seed + GOLDEN_GAMMA;
    gen_mix  = splitmix_finish(seq);
    seq      = seq + GOLDEN_GAMMA;
    gen_loop = splitmix_finish(seq);
    seq      = seq + GOLDEN_GAMMA;
    gen_weyl = splitmix_finish(seq);
    for (int r = 0; r < WARMUP; r++) begin
      discard = gen_advance();
    end
  endfunction

  // Entered and left at a falling edge.
  task automatic send_word(input logic act, input word_t seed, input logic known,
                           input word_t want);
    word_t got;
    while (!quiet_stretch() && $urandom_range(99) < 21) begin
      item_valid <= 1'b0;
      action     <= $urandom_range(1);
      seed_value <= {$urandom, $urandom};
      @(negedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    seed_value <= seed;
    do @(posedge clk); while (item_stall);
    if (act == ACT_NEXT) begin
      got = gen_advance();
      expected_randoms.push_back(known ? want : got);
    end else begin
      gen_reseed(seed);
    end
    words_sent++;
    @(negedge clk);
  endtask

  // Sender: reset, directed table, random words, drain, verdict.
  initial begin
    logic  act;
    word_t seed;
    gen_mix    = '0;
    gen_loop   = '0;
    gen_weyl   = '0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    action     <= ACT_NEXT;
    seed_value <= '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].act, directed_rows[i].seed,
                directed_rows[i].known, directed_rows[i].want);
    end

    // mostly next words; a reseed now and then, sometimes at a seed extreme
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      act  = ($urandom_range(9) == 0) ? ACT_RESEED : ACT_NEXT;
      seed = {$urandom, $urandom};
      case ($urandom_range(15))
        0: seed = '0;
        1: seed = '1;
        default: ;
      endcase
      send_word(act, seed, 1'b0, '0);
    end
    item_valid <= 1'b0;

    while (expected_randoms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold to back the block up, a quiet stretch.
  initial begin
    bit held;
    held = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (!held && words_sent >= HOLD_AFTER) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_stall <= quiet_stretch() ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_randoms.size() == 0) begin
        $display("%0t: unexpected random_value %h, none expected", $time, random_value);
        mismatches++;
      end else begin
        want = expected_randoms.pop_front();
        if (random_value !== want) begin
          $display("%0t: random_value mismatch: expected %h, got %h",
                   $time, want, random_value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
